// ===== rtl/core/frp_pkg.sv =====
// ----------------------------------------------------------------------------
// frp_pkg: shared types and constants for the FTP reply parser
// Byte codes, line limits, queue sizing, item and result records.
// ----------------------------------------------------------------------------
package frp_pkg;

  // longest line, counted in non-LF bytes; the LINE_CHARS-th byte is an error
  localparam int LINE_CHARS = 1024;
  localparam int POS_W      = $clog2(LINE_CHARS);
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(LINE_CHARS - 1);

  localparam int CODE_W = 10;
  localparam int HELD_W = 11;
  localparam int EFF_W  = 3;
  localparam logic [EFF_W-1:0]  EFF_FULL = 3'd4;
  localparam logic [CODE_W-1:0] CODE_MIN = 10'd100;
  localparam logic [CODE_W-1:0] CODE_END = 10'd700;

  // stream widths
  localparam int S_TDATA_W = 8;
  localparam int M_TDATA_W = 40;
  localparam int M_TUSER_W = 2;
  localparam int PAD_W     = M_TDATA_W - (8 + HELD_W + 1 + CODE_W + 3);

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_HY  = 8'h2D;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_9   = 8'h39;

  typedef enum logic {CMD_BYTE = 1'b0, CMD_CLOSE = 1'b1} cmd_t;

  typedef enum logic [1:0] {
    KIND_MSG  = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_SHORT    = 3'd1,
    ERR_DIGIT    = 3'd2,
    ERR_SEP      = 3'd3,
    ERR_RANGE    = 3'd4,
    ERR_MISMATCH = 3'd5,
    ERR_LONG     = 3'd6,
    ERR_CLOSED   = 3'd7
  } err_t;

  typedef enum logic {PH_FIRST = 1'b0, PH_MULTI = 1'b1} phase_t;

  typedef enum logic [1:0] {
    CLS_UNDECIDED = 2'd0,
    CLS_HEADER    = 2'd1,
    CLS_CONT      = 2'd2,
    CLS_END       = 2'd3
  } cls_t;

  typedef enum logic [1:0] {
    SEP_OTHER  = 2'd0,
    SEP_SPACE  = 2'd1,
    SEP_HYPHEN = 2'd2
  } sep_t;

  // classified input word
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data;
    logic       is_lf;
    logic       is_cr;
    logic       is_nul;
    logic       is_space;
    logic       is_hyphen;
    logic       is_digit;
    logic [3:0] digit;
  } item_t;

  // one result word
  typedef struct packed {
    kind_t             kind;
    logic [7:0]        msg_byte;
    logic [HELD_W-1:0] held;
    logic              line_start;
    logic [CODE_W-1:0] code;
    err_t              err;
  } res_t;

endpackage

// ===== rtl/core/ftp_reply_parser.sv =====
// ----------------------------------------------------------------------------
// ftp_reply_parser: FTP control-channel reply framing
// Splits control bytes into lines, checks reply codes, streams message text.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                         tuser     word
//  s_*      in   [7:0] rx_byte                 [0] cmd   one byte or a close
//  m_*      out  byte/held CRs/start/code/err  [1:0] kind text byte or verdict
//
//  One byte per cycle sustained while the output is accepted; each word is
//  classified into the queue, then the engine moves it to the output register.
//  Synchronous active-high reset clears the queue and all reply state.
//  A stalled output register halts only the engine; the front keeps taking
//  words until the four-entry queue fills.
// ----------------------------------------------------------------------------
module ftp_reply_parser (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [frp_pkg::S_TDATA_W-1:0]   s_tdata,  // [7:0] rx_byte
  input  logic                            s_tuser,  // [0] cmd (1 = stream closed)
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [7:0] msg_byte, [18:8] held_cr_count, [19] line_start,
  // [29:20] reply_code, [32:30] error_code, [39:33] zero
  output logic [frp_pkg::M_TDATA_W-1:0]   m_tdata,
  output logic [frp_pkg::M_TUSER_W-1:0]   m_tuser   // [1:0] kind
);
  import frp_pkg::*;

  logic  q_full;
  logic  q_empty;
  logic  push;
  logic  pop;
  item_t push_item;
  item_t pop_item;

  // front: handshake and character classification
  frp_front u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  // decoupling queue
  frp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  // back: line/reply state and output register
  frp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_item (pop_item),
    .empty    (q_empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== rtl/core/frp_front.sv =====
// ----------------------------------------------------------------------------
// frp_front: input side of the reply parser
// Takes stream words and tags each byte with its character class.
// ----------------------------------------------------------------------------
module frp_front (
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [7:0]      s_tdata,   // [7:0] rx_byte
  input  logic            s_tuser,   // [0] cmd
  input  logic            q_full,
  output logic            push,
  output frp_pkg::item_t  push_item
);
  import frp_pkg::*;

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  always_comb begin
    push_item.cmd       = cmd_t'(s_tuser);
    push_item.data      = s_tdata;
    push_item.is_lf     = (s_tdata == CH_LF);
    push_item.is_cr     = (s_tdata == CH_CR);
    push_item.is_nul    = (s_tdata == CH_NUL);
    push_item.is_space  = (s_tdata == CH_SP);
    push_item.is_hyphen = (s_tdata == CH_HY);
    push_item.is_digit  = (s_tdata >= CH_0) && (s_tdata <= CH_9);
    // ASCII digits carry their value in the low nibble
    push_item.digit     = s_tdata[3:0];
  end

endmodule

// ===== rtl/core/frp_queue.sv =====
// ----------------------------------------------------------------------------
// frp_queue: short FIFO between front and back
// Holds classified bytes so either side can stall independently.
// ----------------------------------------------------------------------------
module frp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  frp_pkg::item_t  push_item,
  output logic            full,
  input  logic            pop,
  output frp_pkg::item_t  pop_item,
  output logic            empty
);
  import frp_pkg::*;

  item_t          mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign full     = (count == (QAW+1)'(QDEPTH));
  assign empty    = (count == '0);
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/frp_back.sv =====
// ----------------------------------------------------------------------------
// frp_back: reply framing engine and output register
// Tracks line and reply state, streams text, reports completion or error.
// ----------------------------------------------------------------------------
module frp_back (
  input  logic                            clk,
  input  logic                            rst,
  input  frp_pkg::item_t                  pop_item,
  input  logic                            empty,
  output logic                            pop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [frp_pkg::M_TDATA_W-1:0]   m_tdata,
  output logic [frp_pkg::M_TUSER_W-1:0]   m_tuser
);
  import frp_pkg::*;

  phase_t            phase, phase_next;
  cls_t              cls, cls_next;
  logic [POS_W-1:0]  pos, pos_next;
  logic [CODE_W-1:0] code, code_next;
  logic [CODE_W-1:0] first_code, first_code_next;
  logic [POS_W-1:0]  pend, pend_next;
  logic              nul_seen, nul_seen_next;
  logic              sep_due, sep_due_next;
  logic [EFF_W-1:0]  eff, eff_next;
  logic              bad, bad_next;
  sep_t              sep, sep_next;

  logic              out_valid;
  res_t              out_res;
  res_t              res;
  logic              res_valid;

  // line-end evaluation
  logic              fin_result;
  logic              fin_more;
  res_t              fin_res;
  logic              range_bad;
  cls_t              cls_new;
  logic              region;
  logic [CODE_W-1:0] code_x10;

  assign pop       = !empty && (!out_valid || m_tready);
  assign range_bad = (code < CODE_MIN) || (code >= CODE_END);
  assign code_x10  = (code << 3) + (code << 1);

  always_comb begin
    fin_res    = '{kind: KIND_ERR, msg_byte: '0, held: '0, line_start: 1'b0,
                   code: '0, err: ERR_NONE};
    fin_result = 1'b1;
    fin_more   = 1'b0;
    if (phase == PH_FIRST) begin
      priority if (eff < EFF_FULL)                           fin_res.err = ERR_SHORT;
      else if (bad)                                          fin_res.err = ERR_DIGIT;
      else if (sep != SEP_SPACE && sep != SEP_HYPHEN)        fin_res.err = ERR_SEP;
      else if (range_bad)                                    fin_res.err = ERR_RANGE;
      else if (sep == SEP_SPACE) begin
        fin_res.kind = KIND_DONE;
        fin_res.code = code;
      end else begin
        fin_result = 1'b0;
        fin_more   = 1'b1;
      end
    end else begin
      // an empty line reads as code zero
      priority if (eff == '0)                                fin_res.err = ERR_RANGE;
      else if (cls == CLS_CONT) begin
        fin_result = 1'b0;
        fin_more   = 1'b1;
      end
      else if (eff < EFF_FULL)                               fin_res.err = ERR_SHORT;
      else if (bad)                                          fin_res.err = ERR_DIGIT;
      else if (sep != SEP_SPACE)                             fin_res.err = ERR_SEP;
      else if (range_bad)                                    fin_res.err = ERR_RANGE;
      else if (code != first_code)                           fin_res.err = ERR_MISMATCH;
      else begin
        fin_res.kind = KIND_DONE;
        fin_res.code = first_code;
      end
    end
  end

  always_comb begin
    phase_next      = phase;
    cls_next        = cls;
    pos_next        = pos;
    code_next       = code;
    first_code_next = first_code;
    pend_next       = pend;
    nul_seen_next   = nul_seen;
    sep_due_next    = sep_due;
    eff_next        = eff;
    bad_next        = bad;
    sep_next        = sep;
    res             = '{kind: KIND_ERR, msg_byte: '0, held: '0, line_start: 1'b0,
                        code: '0, err: ERR_NONE};
    res_valid       = 1'b0;
    cls_new         = cls;
    region          = 1'b0;

    if (pop) begin
      if (pop_item.cmd == CMD_CLOSE || pop_item.is_lf || pos >= POS_LIMIT) begin
        // line ends here (or the reply dies): start a fresh line
        cls_next      = CLS_UNDECIDED;
        pos_next      = '0;
        code_next     = '0;
        pend_next     = '0;
        nul_seen_next = 1'b0;
        eff_next      = '0;
        bad_next      = 1'b0;
        sep_next      = SEP_OTHER;
        res_valid     = 1'b1;
        priority if (pop_item.cmd == CMD_CLOSE) begin
          res.err = ERR_CLOSED;
          if (pos != '0 && fin_result) res = fin_res;
        end else if (pop_item.is_lf) begin
          res       = fin_res;
          res_valid = fin_result;
        end else begin
          res.err = ERR_LONG;
        end
        if (res_valid) begin
          phase_next      = PH_FIRST;
          first_code_next = '0;
          sep_due_next    = 1'b0;
        end else if (fin_more) begin
          if (phase == PH_FIRST) first_code_next = code;
          phase_next   = PH_MULTI;
          sep_due_next = 1'b1;
        end
      end else begin
        pos_next = pos + 1'b1;
        if (pos == '0) begin
          if (phase == PH_FIRST)      cls_new = CLS_HEADER;
          else if (pop_item.is_space) cls_new = CLS_CONT;
          else                        cls_new = CLS_END;
        end
        cls_next = cls_new;
        if (!nul_seen) begin
          if (pop_item.is_nul) begin
            nul_seen_next = 1'b1;
          end else begin
            if (pos < POS_W'(3)) begin
              if (pop_item.is_digit) code_next = code_x10 + CODE_W'(pop_item.digit);
              else                   bad_next  = 1'b1;
            end else if (pos == POS_W'(3)) begin
              priority if (pop_item.is_space) sep_next = SEP_SPACE;
              else if (pop_item.is_hyphen)    sep_next = SEP_HYPHEN;
              else                            sep_next = SEP_OTHER;
            end
            if (!pop_item.is_cr) begin
              eff_next = (pos < POS_W'(3)) ? ({1'b0, pos[1:0]} + 3'd1) : EFF_FULL;
            end
            region = (cls_new == CLS_CONT) ? (pos >= POS_W'(1)) : (pos >= POS_W'(4));
            if (region) begin
              if (pop_item.is_cr) begin
                pend_next = pend + 1'b1;
              end else begin
                res_valid      = 1'b1;
                res.kind       = KIND_MSG;
                res.msg_byte   = pop_item.data;
                res.held       = HELD_W'(pend);
                res.line_start = sep_due;
                pend_next      = '0;
                sep_due_next   = 1'b0;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_FIRST;
      cls        <= CLS_UNDECIDED;
      pos        <= '0;
      code       <= '0;
      first_code <= '0;
      pend       <= '0;
      nul_seen   <= 1'b0;
      sep_due    <= 1'b0;
      eff        <= '0;
      bad        <= 1'b0;
      sep        <= SEP_OTHER;
      out_valid  <= 1'b0;
    end else begin
      phase      <= phase_next;
      cls        <= cls_next;
      pos        <= pos_next;
      code       <= code_next;
      first_code <= first_code_next;
      pend       <= pend_next;
      nul_seen   <= nul_seen_next;
      sep_due    <= sep_due_next;
      eff        <= eff_next;
      bad        <= bad_next;
      sep        <= sep_next;
      if (pop && res_valid) out_valid <= 1'b1;
      else if (m_tready)    out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && res_valid) out_res <= res;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{PAD_W{1'b0}}, out_res.err, out_res.code, out_res.line_start,
                     out_res.held, out_res.msg_byte};
  assign m_tuser  = out_res.kind;

  a_done_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.kind == KIND_DONE |->
      out_res.code >= CODE_MIN && out_res.code < CODE_END)
    else $error("completion with code out of range");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    pop && res_valid && res.kind != KIND_MSG |=> phase == PH_FIRST && pos == '0)
    else $error("reply state not cleared after last word");

  a_msg_drains: assert property (@(posedge clk) disable iff (rst)
    pop && res_valid && res.kind == KIND_MSG |=> pend == '0 && !sep_due)
    else $error("held CRs or separator survived a text byte");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_LIMIT)
    else $error("line position past limit");

endmodule

// ===== dv/ftp_reply_parser_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ftp_reply_parser_test: self-checking bench for the FTP reply parser
// Feeds control-channel words (bytes and stream closes) into the parser,
// mirrors its reply framing in a behavioral model and checks every output
// word in order. Sender bursts and receiver stalls vary all through the run.
// ----------------------------------------------------------------------------
module ftp_reply_parser_test;
  import frp_pkg::*;

  // one control-channel word as it goes on the input stream
  typedef struct {
    cmd_t       c;
    logic [7:0] b;
  } ctl_word_t;

  typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_EVERY4} rx_mode_t;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;
  logic                 s_tuser  = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [M_TUSER_W-1:0] m_tuser;

  ftp_reply_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Framing model: mirrors the parser's line and reply state
  // --------------------------------------------------------------------------
  phase_t      ph;
  cls_t        lcls;
  sep_t        sepk;
  int unsigned lpos;       // non-LF bytes seen in this line
  int unsigned eff;        // line length without trailing CRs
  int unsigned digits;
  int unsigned first_code;
  int unsigned crs;        // CRs held back since the last text byte
  bit          nul;
  bit          bad_digit;
  bit          sep_due;    // next text byte follows a line break

  res_t reply_words_due[$];
  int   mismatches = 0;

  function automatic void clear_line();
    lcls      = CLS_UNDECIDED;
    sepk      = SEP_OTHER;
    lpos      = 0;
    eff       = 0;
    digits    = 0;
    crs       = 0;
    nul       = 1'b0;
    bad_digit = 1'b0;
    sep_due   = (ph == PH_MULTI);
  endfunction

  function automatic void clear_reply();
    ph         = PH_FIRST;
    first_code = 0;
    clear_line();
  endfunction

  function automatic void expect_word(kind_t k, logic [7:0] b, int unsigned held, bit ls,
                                      int unsigned code, err_t e);
    res_t r;
    r.kind       = k;
    r.msg_byte   = b;
    r.held       = HELD_W'(held);
    r.line_start = ls;
    r.code       = CODE_W'(code);
    r.err        = e;
    reply_words_due.push_back(r);
  endfunction

  function automatic void expect_error(err_t e);
    clear_reply();
    expect_word(KIND_ERR, 8'h00, 0, 1'b0, 0, e);
  endfunction

  // line check at LF or close; returns 1 once the reply has a verdict
  function automatic bit close_line();
    int unsigned code;
    code = digits;
    if (ph == PH_FIRST) begin
      if (eff < 4) begin expect_error(ERR_SHORT); return 1'b1; end
      if (bad_digit) begin expect_error(ERR_DIGIT); return 1'b1; end
      if (sepk == SEP_OTHER) begin expect_error(ERR_SEP); return 1'b1; end
      if (code < 100 || code >= 700) begin expect_error(ERR_RANGE); return 1'b1; end
      if (sepk == SEP_SPACE) begin
        clear_reply();
        expect_word(KIND_DONE, 8'h00, 0, 1'b0, code, ERR_NONE);
        return 1'b1;
      end
      first_code = code;
      ph         = PH_MULTI;
      clear_line();
      return 1'b0;
    end
    // blank line inside a multiline reply reads as code 0
    if (eff == 0) begin expect_error(ERR_RANGE); return 1'b1; end
    if (lcls == CLS_CONT) begin
      clear_line();
      return 1'b0;
    end
    if (eff < 4) begin expect_error(ERR_SHORT); return 1'b1; end
    if (bad_digit) begin expect_error(ERR_DIGIT); return 1'b1; end
    if (sepk != SEP_SPACE) begin expect_error(ERR_SEP); return 1'b1; end
    if (code < 100 || code >= 700) begin expect_error(ERR_RANGE); return 1'b1; end
    if (code != first_code) begin expect_error(ERR_MISMATCH); return 1'b1; end
    clear_reply();
    expect_word(KIND_DONE, 8'h00, 0, 1'b0, code, ERR_NONE);
    return 1'b1;
  endfunction

  function automatic void frame_byte(cmd_t c, logic [7:0] b);
    int unsigned p;
    bit          in_text;
    if (c == CMD_CLOSE) begin
      if (lpos == 0) begin expect_error(ERR_CLOSED); return; end
      // partial line is judged as if terminated; an open reply still fails
      if (!close_line()) expect_error(ERR_CLOSED);
      return;
    end
    if (b == CH_LF) begin
      void'(close_line());
      return;
    end
    if (lpos >= LINE_CHARS - 1) begin expect_error(ERR_LONG); return; end
    p    = lpos;
    lpos = p + 1;
    if (p == 0) begin
      if (ph == PH_FIRST) lcls = CLS_HEADER;
      else lcls = (b == CH_SP) ? CLS_CONT : CLS_END;
    end
    if (nul) return;
    if (b == CH_NUL) begin
      nul = 1'b1;
      return;
    end
    if (p < 3) begin
      if (b >= CH_0 && b <= CH_9) digits = digits * 10 + (b - CH_0);
      else bad_digit = 1'b1;
    end else if (p == 3) begin
      sepk = (b == CH_SP) ? SEP_SPACE : (b == CH_HY) ? SEP_HYPHEN : SEP_OTHER;
    end
    if (b != CH_CR) eff = p + 1;
    in_text = (lcls == CLS_CONT) ? (p >= 1) : (p >= 4);
    if (!in_text) return;
    if (b == CH_CR) begin
      crs++;
      return;
    end
    expect_word(KIND_MSG, b, crs, sep_due, 0, ERR_NONE);
    crs     = 0;
    sep_due = 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // Output checker
  // --------------------------------------------------------------------------
  task automatic flag_word(string why, res_t want, res_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t mismatch (%s): want kind %0d byte %h held %0d start %0d code %0d err %0d,",
               $realtime, why, want.kind, want.msg_byte, want.held, want.line_start,
               want.code, want.err,
               " got kind %0d byte %h held %0d start %0d code %0d err %0d pad %h",
               got.kind, got.msg_byte, got.held, got.line_start, got.code, got.err,
               m_tdata[M_TDATA_W-1:33]);
  endtask

  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.kind       = kind_t'(m_tuser);
      got.msg_byte   = m_tdata[7:0];
      got.held       = m_tdata[18:8];
      got.line_start = m_tdata[19];
      got.code       = m_tdata[29:20];
      got.err        = err_t'(m_tdata[32:30]);
      if (reply_words_due.size() == 0) begin
        want = '0;
        flag_word("unexpected word", want, got);
      end else begin
        want = reply_words_due.pop_front();
        if (got !== want || m_tdata[M_TDATA_W-1:33] !== '0)
          flag_word("wrong field", want, got);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall pattern of its own, plus long hold-offs on request
  // --------------------------------------------------------------------------
  rx_mode_t    rx_mode      = RX_OPEN;
  int unsigned mode_left    = 0;
  int unsigned cyc          = 0;
  int unsigned hold_left    = 0;
  int unsigned holds_asked  = 0;
  int unsigned holds_done   = 0;

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      holds_done <= holds_done + 1;
      hold_left  <= 250;
      m_tready   <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   <= rx_mode_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        RX_OPEN:   m_tready <= 1'b1;
        RX_LIGHT:  m_tready <= ($urandom_range(0, 3) != 0);
        RX_HEAVY:  m_tready <= ($urandom_range(0, 3) == 0);
        default:   m_tready <= (cyc[1:0] == 2'd0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned words_sent = 0;
  ctl_word_t   outbox[$];

  // words go out in bursts; the model sees each word as it is offered,
  // which matches acceptance order since the sender never skips a word
  task automatic send_word(cmd_t c, logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 120)
                                                : $urandom_range(1, 16);
    end
    frame_byte(c, b);
    s_tvalid <= 1'b1;
    s_tuser  <= c;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    words_sent++;
  endtask

  task automatic queue_byte(logic [7:0] b);
    ctl_word_t w;
    w.c = CMD_BYTE;
    w.b = b;
    outbox.push_back(w);
  endtask

  task automatic queue_close();
    ctl_word_t w;
    w.c = CMD_CLOSE;
    w.b = 8'($urandom_range(0, 255));  // payload ignored on close
    outbox.push_back(w);
  endtask

  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endtask

  task automatic queue_run(logic [7:0] b, int unsigned n);
    repeat (n) queue_byte(b);
  endtask

  task automatic send_outbox();
    ctl_word_t w;
    while (outbox.size() != 0) begin
      w = outbox.pop_front();
      send_word(w.c, w.b);
    end
  endtask

  // --------------------------------------------------------------------------
  // Random reply builder
  // --------------------------------------------------------------------------
  function automatic logic [7:0] text_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 8'($urandom_range(8'h20, 8'h7E));
    if (r < 80) return CH_CR;
    if (r < 95) return 8'($urandom_range(8'h80, 8'hFF));
    text_byte = 8'($urandom_range(1, 255));
    if (text_byte == CH_LF) text_byte = CH_CR;
  endfunction

  task automatic queue_code(int unsigned code);
    queue_byte(CH_0 + 8'(code / 100));
    queue_byte(CH_0 + 8'((code / 10) % 10));
    queue_byte(CH_0 + 8'(code % 10));
  endtask

  task automatic queue_text_tail();
    int unsigned n;
    n = $urandom_range(0, 12);
    repeat (n) queue_byte(text_byte());
    queue_run(CH_CR, $urandom_range(0, 2));
    queue_byte(CH_LF);
  endtask

  task automatic queue_reply();
    int unsigned code;
    int unsigned conts;
    bit          multi;
    code  = $urandom_range(100, 699);
    multi = $urandom_range(0, 1);
    conts = $urandom_range(0, 3);
    queue_code(code);
    queue_byte(multi ? CH_HY : CH_SP);
    queue_text_tail();
    if (multi) begin
      repeat (conts) begin
        queue_byte(CH_SP);
        queue_text_tail();
      end
      queue_code(code);
      queue_byte(CH_SP);
      queue_text_tail();
    end
  endtask

  // break a well-formed reply: a stray byte, an early close or a NUL
  task automatic mangle_outbox();
    ctl_word_t   w;
    int unsigned at;
    at = $urandom_range(0, outbox.size() - 1);
    case ($urandom_range(0, 2))
      0: outbox[at].b = 8'($urandom_range(0, 255));
      1: begin
        while (outbox.size() > at) void'(outbox.pop_back());
        queue_close();
      end
      default: begin
        w.c = CMD_BYTE;
        w.b = CH_NUL;
        outbox.insert(at, w);
      end
    endcase
  endtask

  task automatic queue_noise();
    int unsigned n;
    n = $urandom_range(1, 16);
    repeat (n) queue_byte(($urandom_range(0, 3) == 0) ? CH_LF : 8'($urandom_range(0, 255)));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_single_line();
    queue_text("220 Hi\r\n");
    queue_text("100 \n");       // lowest code, no text
    queue_text("699 x\r\r\n");  // highest code
    send_outbox();
  endtask

  task automatic test_multiline();
    queue_text("150-Open\r\n");
    queue_text(" more\r\rtext\r\r\n");
    queue_text(" \n");          // continuation with nothing after the space
    queue_text("150 End\n");
    send_outbox();
  endtask

  task automatic test_bad_lines();
    queue_text("12\n");                 // short
    queue_text("1a3 x\n");              // non-digit
    queue_byte(8'hB2);                  // high byte in the digit field
    queue_text("00 x\n");
    queue_text("200x\n");               // bad separator
    queue_text("099 x\n");              // below range
    queue_text("700 x\n");              // above range
    queue_text("200-a\n201 b\n");       // code mismatch
    queue_text("200-a\n200-b\n");       // ending line needs a space
    queue_text("200-a\n\n");            // blank line inside a multiline reply
    queue_text("200 ab");               // NUL cuts the text short
    queue_byte(CH_NUL);
    queue_text("cd\r\n");
    queue_text("2");                    // NUL inside the code
    queue_byte(CH_NUL);
    queue_text("00 x\n");
    send_outbox();
  endtask

  task automatic test_close();
    queue_close();                      // nothing in the line
    queue_text("200 ok");
    queue_close();                      // partial line completes the reply
    queue_text("200-a\n");
    queue_close();
    queue_text("200-ab");
    queue_close();                      // header passes, reply still open
    queue_text("230-x\n y");
    queue_close();                      // inside a continuation line
    send_outbox();
  endtask

  task automatic test_long_lines();
    queue_text("200 ");
    queue_run("a", LINE_CHARS - 5);     // longest legal line
    queue_byte(CH_LF);
    queue_text("200 ");
    queue_run("b", LINE_CHARS - 4);     // last byte overflows the line
    queue_text("220 z\n");              // next byte starts a fresh reply
    queue_text("200 ");
    queue_run(CH_CR, 1000);             // deep pile of held CRs
    queue_text("x\n");
    send_outbox();
  endtask

  task automatic test_backpressure();
    s_tvalid <= 1'b0;                   // last word is already taken
    holds_asked++;
    @(posedge clk);
    while (hold_left == 0) @(posedge clk);
    burst_left = 500;                   // keep offering while the output is held
    queue_text("211-");
    repeat (60) queue_byte(8'($urandom_range(8'h21, 8'h7E)));
    queue_text("\n211 end\n");
    send_outbox();
  endtask

  task automatic test_random_traffic();
    int unsigned start;
    int unsigned pick;
    start = words_sent;
    while (words_sent - start < 750) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        queue_noise();
      end else begin
        queue_reply();
        if (pick >= 7) mangle_outbox();
      end
      send_outbox();
    end
    queue_close();                      // flush whatever reply is still open
    send_outbox();
  endtask

  initial begin
    clear_reply();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_line();
    test_multiline();
    test_bad_lines();
    test_close();
    test_long_lines();
    test_backpressure();
    test_random_traffic();
    s_tvalid <= 1'b0;
    while (reply_words_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS ftp_reply_parser");
    end else begin
      $display("FAIL ftp_reply_parser");
    end
    $finish;
  end

  // run limit: several times the slowest legal run
  initial begin
    #5_000_000;
    $display("FAIL ftp_reply_parser");
    $finish;
  end

endmodule
